>>> rtl/core/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, constants and helpers of the fuzzy brake controller: field
// widths, register indexes, set breakpoints and brake class codes.
// ----------------------------------------------------------------------------
package fbc_pkg;

    // Field widths of the streams and of the configuration port.
    localparam int XW       = 12;   // distance and speed, unsigned fixed point
    localparam int LEVEL_W  = 11;   // brake level and singleton levels
    localparam int CLASS_W  = 2;    // brake class
    localparam int IDX_W    = 2;    // configuration register index
    localparam int S_DATA_W = 24;   // input item, packed
    localparam int M_DATA_W = 16;   // result item, packed and padded to bytes

    // Defaults of the top-level parameters.
    localparam int DEF_INPUT_FRAC_BITS = 4;
    localparam int DEF_GRADE_BITS      = 8;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_LEVEL_SOFT     = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL_MODERATE = 2'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_HARD     = 2'd2;

    // Reset values of the singleton levels, 1/16 units.
    localparam logic [LEVEL_W-1:0] RST_LEVEL_SOFT     = 11'd400;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_MODERATE = 11'd800;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_HARD     = 11'd1600;

    // Set breakpoints in whole units: first corner, spacing and number of
    // ramp segments. Distance: 2/6/10/14 m, speed: 20/40/60 km/h.
    localparam int DIST_BASE  = 2;
    localparam int DIST_STEP  = 4;
    localparam int DIST_SEGS  = 3;
    localparam int SPEED_BASE = 20;
    localparam int SPEED_STEP = 20;
    localparam int SPEED_SEGS = 2;

    // Class thresholds on the exact average, 1/16 units (25.0 and 50.0).
    localparam int CLASS_SOFT_MAX = 400;
    localparam int CLASS_MOD_MAX  = 800;

    // Brake class codes.
    localparam logic [CLASS_W-1:0] CLASS_NONE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SOFT     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MODERATE = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HARD     = 2'd3;

    // Side information that rides along with an item through the divider.
    typedef struct packed {
        logic               zero;   // total grade was zero
        logic [CLASS_W-1:0] cls;    // brake class
    } fbc_side_t;

    // Number of trailing zero bits of a positive constant.
    function automatic int ctz(input int v);
        int   n;
        logic done;
        n    = 0;
        done = 1'b0;
        for (int i = 0; i < 31; i++) begin
            if (!done && !v[i]) begin
                n = n + 1;
            end else begin
                done = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/fbc_fuzzify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_fuzzify
// Two-stage fuzzifier for a row of evenly spaced sets: a left shoulder,
// triangles and a right shoulder. The first stage finds the segment and the
// ramp distances, the second scales them to grades with a reciprocal multiply.
// ----------------------------------------------------------------------------
module fbc_fuzzify #(
    parameter int FRAC_BITS  = fbc_pkg::DEF_INPUT_FRAC_BITS,
    parameter int GRADE_BITS = fbc_pkg::DEF_GRADE_BITS,
    parameter int BASE       = fbc_pkg::DIST_BASE,
    parameter int STEP       = fbc_pkg::DIST_STEP,
    parameter int NSEG       = fbc_pkg::DIST_SEGS
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [fbc_pkg::XW-1:0]              x,
    output logic [NSEG:0][GRADE_BITS:0]         grade
);

    localparam int GW     = GRADE_BITS + 1;
    // Ramp width is ODD * 2^(FRAC_BITS + P) in input units.
    localparam int P      = fbc_pkg::ctz(STEP);
    localparam int ODD    = STEP >> P;
    localparam int L      = $clog2(ODD);
    localparam int RW     = FRAC_BITS + P + L;
    localparam int YW     = GRADE_BITS + L;
    localparam int SH     = YW + L;
    localparam int MW     = YW + 1;
    localparam int PW     = YW + MW;
    localparam longint unsigned M_VAL =
        ((64'd1 << SH) + 64'(ODD) - 64'd1) / 64'(ODD);
    localparam logic [MW-1:0] M_MULT = MW'(M_VAL);
    localparam int TOP_BP = (BASE + NSEG * STEP) << FRAC_BITS;
    localparam int BPW    = $clog2(TOP_BP + 1);
    localparam int CW     = (BPW > fbc_pkg::XW) ? BPW : fbc_pkg::XW;

    // Breakpoint k in input units.
    function automatic logic [CW-1:0] bp(input int k);
        return CW'((BASE + k * STEP) << FRAC_BITS);
    endfunction

    // Stage A: segment search and ramp distances.
    logic [CW-1:0]          xe;
    logic [NSEG:0]          full_next;
    logic [NSEG-1:0]        seg_next;
    logic [CW-1:0]          lo_sel;
    logic [CW-1:0]          hi_sel;
    logic [CW-1:0]          rise_w;
    logic [CW-1:0]          fall_w;
    logic [RW+GRADE_BITS-1:0] rise_sc;
    logic [RW+GRADE_BITS-1:0] fall_sc;

    always_comb begin
        xe           = CW'(x);
        full_next    = '0;
        full_next[0] = (xe <= bp(0));
        full_next[NSEG] = (xe >= bp(NSEG));
        for (int k = 1; k < NSEG; k++) begin
            full_next[k] = (xe == bp(k));
        end
        lo_sel = '0;
        hi_sel = '0;
        for (int k = 0; k < NSEG; k++) begin
            seg_next[k] = (xe > bp(k)) && (xe < bp(k + 1));
            if (seg_next[k]) begin
                lo_sel = lo_sel | bp(k);
                hi_sel = hi_sel | bp(k + 1);
            end
        end
        rise_w  = xe - lo_sel;
        fall_w  = hi_sel - xe;
        rise_sc = {rise_w[RW-1:0], {GRADE_BITS{1'b0}}};
        fall_sc = {fall_w[RW-1:0], {GRADE_BITS{1'b0}}};
    end

    logic [NSEG:0]   full_a_reg;
    logic [NSEG-1:0] seg_a_reg;
    logic [YW-1:0]   y_rise_reg;
    logic [YW-1:0]   y_fall_reg;

    // The power-of-two part of the ramp width is a plain bit drop.
    always_ff @(posedge aclk) begin
        if (en) begin
            full_a_reg <= full_next;
            seg_a_reg  <= seg_next;
            y_rise_reg <= rise_sc[RW+GRADE_BITS-1 -: YW];
            y_fall_reg <= fall_sc[RW+GRADE_BITS-1 -: YW];
        end
    end

    // Stage B: the odd part of the ramp width by reciprocal multiply.
    logic [PW-1:0] prod_rise;
    logic [PW-1:0] prod_fall;

    assign prod_rise = PW'(y_rise_reg) * PW'(M_MULT);
    assign prod_fall = PW'(y_fall_reg) * PW'(M_MULT);

    logic [NSEG:0]           full_b_reg;
    logic [NSEG-1:0]         seg_b_reg;
    logic [GRADE_BITS-1:0]   q_rise_reg;
    logic [GRADE_BITS-1:0]   q_fall_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            full_b_reg <= full_a_reg;
            seg_b_reg  <= seg_a_reg;
            q_rise_reg <= prod_rise[SH +: GRADE_BITS];
            q_fall_reg <= prod_fall[SH +: GRADE_BITS];
        end
    end

    // Set k takes the falling ramp of segment k and the rising ramp of k-1.
    always_comb begin
        for (int j = 0; j <= NSEG; j++) begin
            grade[j] = full_b_reg[j] ? {1'b1, {GRADE_BITS{1'b0}}} : '0;
        end
        for (int k = 0; k < NSEG; k++) begin
            if (seg_b_reg[k]) begin
                grade[k]     = grade[k] | GW'(q_fall_reg);
                grade[k + 1] = grade[k + 1] | GW'(q_rise_reg);
            end
        end
    end

endmodule

>>> rtl/core/fbc_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_divide
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit QW bits. The quotient is forced to zero when the side flag zero is set.
// ----------------------------------------------------------------------------
module fbc_divide #(
    parameter int NW = 21,
    parameter int DW = 11,
    parameter int QW = fbc_pkg::LEVEL_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  fbc_pkg::fbc_side_t  in_side,
    output logic                out_valid,
    output logic [QW-1:0]       quotient,
    output fbc_pkg::fbc_side_t  out_side
);

    logic               valid_reg [QW];
    logic [QW-1:0]      q_reg     [QW];
    fbc_pkg::fbc_side_t side_reg  [QW];
    logic [NW-1:0]      rem_reg   [QW-1];
    logic [DW-1:0]      den_reg   [QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int B = QW - 1 - i;

        logic               v_in;
        logic [NW-1:0]      rem_in;
        logic [DW-1:0]      den_in;
        logic [QW-1:0]      q_in;
        fbc_pkg::fbc_side_t side_in;
        logic [NW-1:0]      trial;
        logic               take;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = num;
            assign den_in  = den;
            assign q_in    = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[i - 1];
            assign rem_in  = rem_reg[i - 1];
            assign den_in  = den_reg[i - 1];
            assign q_in    = q_reg[i - 1];
            assign side_in = side_reg[i - 1];
        end

        // Try the divisor at this bit weight.
        assign trial = NW'(den_in) << B;
        assign take  = (rem_in >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i]    <= q_in | (take ? (QW'(1) << B) : '0);
                side_reg[i] <= side_in;
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? (rem_in - trial) : rem_in;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign quotient  = side_reg[QW-1].zero ? '0 : q_reg[QW-1];

endmodule

>>> rtl/core/fuzzy_brake_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_brake_controller
// Fuzzy brake controller: fuzzifies distance and speed, applies twelve
// min/max rules and defuzzifies by a weighted average of singleton levels.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_tvalid / s_tready   distance, speed
//   m_        out        m_tvalid / m_tready   brake level, brake class
//   cfg_      in         cfg_valid / cfg_ready register index, level value
//
// One item is accepted per cycle while the output is not stalled. On its way
// out an item passes two fuzzifier stages, rules, products, sum, class,
// and eleven divider stages, one per quotient bit.
// Reset is synchronous and active low; it clears the valid bits, the input
// skid register and restores the singleton levels.
// A stall on m_tready freezes the whole pipeline; an item accepted in that
// cycle is parked in the input skid register, and s_tready drops until it
// moves on. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module fuzzy_brake_controller #(
    parameter int INPUT_FRAC_BITS = fbc_pkg::DEF_INPUT_FRAC_BITS,
    parameter int GRADE_BITS      = fbc_pkg::DEF_GRADE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbc_pkg::S_DATA_W-1:0]    s_tdata,   // distance_q4, speed_q4
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbc_pkg::M_DATA_W-1:0]    m_tdata,   // brake_level, brake_class
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fbc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [fbc_pkg::LEVEL_W-1:0]     cfg_data
);

    localparam int XW    = fbc_pkg::XW;
    localparam int LW    = fbc_pkg::LEVEL_W;
    localparam int GW    = GRADE_BITS + 1;
    localparam int TW    = GW + 2;
    localparam int PRW   = GW + LW;
    localparam int NW    = GW + 12;
    localparam int PAD_W = fbc_pkg::M_DATA_W - LW - fbc_pkg::CLASS_W;

    // Configuration registers.
    logic [LW-1:0] level_soft_reg;
    logic [LW-1:0] level_mod_reg;
    logic [LW-1:0] level_hard_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_soft_reg <= fbc_pkg::RST_LEVEL_SOFT;
            level_mod_reg  <= fbc_pkg::RST_LEVEL_MODERATE;
            level_hard_reg <= fbc_pkg::RST_LEVEL_HARD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fbc_pkg::REG_LEVEL_SOFT:     level_soft_reg <= cfg_data;
                fbc_pkg::REG_LEVEL_MODERATE: level_mod_reg  <= cfg_data;
                fbc_pkg::REG_LEVEL_HARD:     level_hard_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance and input skid register.
    logic                          en;
    logic                          s_accept;
    logic                          skid_valid_reg;
    logic [fbc_pkg::S_DATA_W-1:0]  skid_data_reg;
    logic                          feed_valid;
    logic [fbc_pkg::S_DATA_W-1:0]  feed_data;

    assign en         = !m_tvalid || m_tready;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign feed_valid = skid_valid_reg || s_accept;
    assign feed_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_accept) begin
            skid_data_reg <= s_tdata;
        end
    end

    // Valid bits of the stages ahead of the divider.
    logic [5:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], feed_valid};
        end
    end

    // Stages 1 and 2: fuzzification.
    logic [fbc_pkg::DIST_SEGS:0][GW-1:0]  d_grade;
    logic [fbc_pkg::SPEED_SEGS:0][GW-1:0] s_grade;

    fbc_fuzzify #(
        .FRAC_BITS  (INPUT_FRAC_BITS),
        .GRADE_BITS (GRADE_BITS),
        .BASE       (fbc_pkg::DIST_BASE),
        .STEP       (fbc_pkg::DIST_STEP),
        .NSEG       (fbc_pkg::DIST_SEGS)
    ) u_fuzz_dist (
        .aclk  (aclk),
        .en    (en),
        .x     (feed_data[XW-1:0]),
        .grade (d_grade)
    );

    fbc_fuzzify #(
        .FRAC_BITS  (INPUT_FRAC_BITS),
        .GRADE_BITS (GRADE_BITS),
        .BASE       (fbc_pkg::SPEED_BASE),
        .STEP       (fbc_pkg::SPEED_STEP),
        .NSEG       (fbc_pkg::SPEED_SEGS)
    ) u_fuzz_speed (
        .aclk  (aclk),
        .en    (en),
        .x     (feed_data[2*XW-1:XW]),
        .grade (s_grade)
    );

    function automatic logic [GW-1:0] gmin(input logic [GW-1:0] a, input logic [GW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [GW-1:0] gmax(input logic [GW-1:0] a, input logic [GW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Stage 3: rule firing and aggregation per braking set.
    logic [GW-1:0] d_short, d_med, d_long, d_vlong;
    logic [GW-1:0] s_low, s_med, s_high;
    logic [GW-1:0] g_none_reg, g_soft_reg, g_mod_reg, g_hard_reg;

    assign d_short = d_grade[0];
    assign d_med   = d_grade[1];
    assign d_long  = d_grade[2];
    assign d_vlong = d_grade[3];
    assign s_low   = s_grade[0];
    assign s_med   = s_grade[1];
    assign s_high  = s_grade[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            g_none_reg <= gmax(gmin(s_low, d_long),
                          gmax(gmin(s_low, d_vlong), gmin(s_med, d_vlong)));
            g_soft_reg <= gmax(gmin(s_low, d_med),
                          gmax(gmin(s_med, d_long), gmin(s_high, d_vlong)));
            g_mod_reg  <= gmax(gmin(s_low, d_short),
                          gmax(gmin(s_med, d_med), gmin(s_high, d_long)));
            g_hard_reg <= gmax(gmin(s_med, d_short),
                          gmax(gmin(s_high, d_short), gmin(s_high, d_med)));
        end
    end

    // Stage 4: total grade and weighted singleton products.
    logic [TW-1:0]  total_reg;
    logic [PRW-1:0] p_soft_reg, p_mod_reg, p_hard_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            total_reg  <= TW'(g_none_reg) + TW'(g_soft_reg) + TW'(g_mod_reg)
                        + TW'(g_hard_reg);
            p_soft_reg <= PRW'(g_soft_reg) * PRW'(level_soft_reg);
            p_mod_reg  <= PRW'(g_mod_reg) * PRW'(level_mod_reg);
            p_hard_reg <= PRW'(g_hard_reg) * PRW'(level_hard_reg);
        end
    end

    // Stage 5: numerator of the weighted average.
    logic [NW-1:0] num_reg;
    logic [TW-1:0] total5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= NW'(p_soft_reg) + NW'(p_mod_reg) + NW'(p_hard_reg);
            total5_reg <= total_reg;
        end
    end

    // Stage 6: brake class from the exact quotient against the thresholds.
    logic [NW-1:0]      t_soft;
    logic [NW-1:0]      t_mod;
    fbc_pkg::fbc_side_t side_next;
    logic [NW-1:0]      div_num_reg;
    logic [TW-1:0]      div_den_reg;
    fbc_pkg::fbc_side_t div_side_reg;

    assign t_soft = NW'(total5_reg) * NW'(fbc_pkg::CLASS_SOFT_MAX);
    assign t_mod  = NW'(total5_reg) * NW'(fbc_pkg::CLASS_MOD_MAX);

    always_comb begin
        side_next.zero = (total5_reg == '0);
        if (side_next.zero || num_reg == '0) begin
            side_next.cls = fbc_pkg::CLASS_NONE;
        end else if (num_reg <= t_soft) begin
            side_next.cls = fbc_pkg::CLASS_SOFT;
        end else if (num_reg <= t_mod) begin
            side_next.cls = fbc_pkg::CLASS_MODERATE;
        end else begin
            side_next.cls = fbc_pkg::CLASS_HARD;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_num_reg  <= num_reg;
            div_den_reg  <= total5_reg;
            div_side_reg <= side_next;
        end
    end

    // Stages 7 to 17: quotient, one bit per stage; the last stage is the
    // output register.
    logic               out_valid;
    logic [LW-1:0]      out_level;
    fbc_pkg::fbc_side_t out_side;

    fbc_divide #(
        .NW (NW),
        .DW (TW),
        .QW (LW)
    ) u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_reg[5]),
        .num       (div_num_reg),
        .den       (div_den_reg),
        .in_side   (div_side_reg),
        .out_valid (out_valid),
        .quotient  (out_level),
        .out_side  (out_side)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{PAD_W{1'b0}}, out_side.cls, out_level};

    // A result of class none always carries a zero level.
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_side.cls == fbc_pkg::CLASS_NONE) |-> (out_level == '0))
        else $error("class none with a nonzero brake level");

    // A truncated level above the soft threshold means the exact one is too.
    a_level_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_level > LW'(fbc_pkg::CLASS_SOFT_MAX))
        |-> (out_side.cls == fbc_pkg::CLASS_MODERATE ||
             out_side.cls == fbc_pkg::CLASS_HARD))
        else $error("brake class below level");

    // An item taken during a stall must be parked in the skid register.
    a_skid_park: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !en) |=> skid_valid_reg)
        else $error("item accepted during stall was dropped");

    // A parked item leaves the skid register as soon as the pipeline moves.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && en) |=> (!skid_valid_reg && valid_reg[0]))
        else $error("parked item did not enter the pipeline");

endmodule
